FILE: rtl/edi_pkg.sv
package edi_pkg;

   // Pixel format: three packed 8-bit channels, channel k in bits 8k+7..8k.
   localparam int NumChannels = 3;
   localparam int ChanWidth   = 8;
   localparam int PixelWidth  = NumChannels * ChanWidth;

   // Cross sums add two channel distances, so they need one extra bit.
   localparam int SumWidth    = ChanWidth + 1;
   localparam int DirWidth    = 2;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [ChanWidth-1:0]  dist_type;
   typedef logic [SumWidth-1:0]   sum_type;
   typedef logic [DirWidth-1:0]   dir_type;

   // Interpolation direction codes.
   localparam dir_type DirUpLeft  = 2'd0;
   localparam dir_type DirVert    = 2'd1;
   localparam dir_type DirUpRight = 2'd2;

   // The six neighbors of one missing pixel.
   typedef struct packed {
      pixel_type above_left;
      pixel_type above_mid;
      pixel_type above_right;
      pixel_type below_left;
      pixel_type below_mid;
      pixel_type below_right;
   } window_type;

   // Distance between two pixels: the largest absolute channel difference.
   function automatic dist_type pix_dist(input pixel_type a, input pixel_type b);
      dist_type worst;
      dist_type x;
      dist_type y;
      dist_type d;
      begin
         worst = '0;
         for (int k = 0; k < NumChannels; k++) begin
            x = a[k*ChanWidth +: ChanWidth];
            y = b[k*ChanWidth +: ChanWidth];
            d = (x > y) ? (x - y) : (y - x);
            if (d > worst) begin
               worst = d;
            end
         end
         return worst;
      end
   endfunction

   // Per-channel floor average of two pixels.
   function automatic pixel_type pix_avg(input pixel_type a, input pixel_type b);
      pixel_type r;
      logic [ChanWidth:0] s;
      begin
         r = '0;
         for (int k = 0; k < NumChannels; k++) begin
            s = {1'b0, a[k*ChanWidth +: ChanWidth]} + {1'b0, b[k*ChanWidth +: ChanWidth]};
            r[k*ChanWidth +: ChanWidth] = s[ChanWidth:1];
         end
         return r;
      end
   endfunction

endpackage

FILE: rtl/edge_directed_deinterlace.sv
// An accepted transaction is held in the input register and then in the result
// register, which drives the result port. Throughput: one transaction per clock
// while rsp_stall is low; the input register and the result register form a
// two-entry pipeline, so input is taken while a result waits.
// Reset (synchronous, active high) clears only the two valid flags.
module edge_directed_deinterlace
   import edi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PixelWidth-1:0] req_above_left,
   input  logic [PixelWidth-1:0] req_above_mid,
   input  logic [PixelWidth-1:0] req_above_right,
   input  logic [PixelWidth-1:0] req_below_left,
   input  logic [PixelWidth-1:0] req_below_mid,
   input  logic [PixelWidth-1:0] req_below_right,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PixelWidth-1:0] rsp_filled_pixel,
   output logic [DirWidth-1:0]   rsp_direction
);

   logic       win_valid_ff;
   logic       win_valid_in;
   window_type win_ff;

   logic       res_valid_ff;
   logic       res_valid_in;
   pixel_type  res_pixel_ff;
   dir_type    res_dir_ff;

   logic       res_load;
   logic       win_free;
   logic       req_take;

   dist_type   c0;
   dist_type   c1;
   dist_type   c2;
   dist_type   c_first;
   sum_type    p_sum;
   sum_type    q_sum;
   dir_type    dir_pick;
   dir_type    dir_first;
   pixel_type  avg_pick;

   // Flow control: the result register loads when empty or being drained,
   // and the input register is free when empty or moving into the result.
   assign res_load  = !res_valid_ff || !rsp_stall;
   assign win_free  = !win_valid_ff || res_load;
   assign req_stall = !win_free;
   assign req_take  = req_valid && win_free;

   always_comb begin
      win_valid_in = win_free ? req_valid : win_valid_ff;
      res_valid_in = res_load ? win_valid_ff : res_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Capture the neighbor window of an accepted transaction.
   always_ff @(posedge clock) begin
      if (req_take) begin
         win_ff.above_left  <= req_above_left;
         win_ff.above_mid   <= req_above_mid;
         win_ff.above_right <= req_above_right;
         win_ff.below_left  <= req_below_left;
         win_ff.below_mid   <= req_below_mid;
         win_ff.below_right <= req_below_right;
      end
   end

   // Cross sums and direction costs.
   always_comb begin
      p_sum = {1'b0, pix_dist(win_ff.above_left, win_ff.below_mid)}
            + {1'b0, pix_dist(win_ff.above_mid, win_ff.below_right)};
      q_sum = {1'b0, pix_dist(win_ff.above_mid, win_ff.below_left)}
            + {1'b0, pix_dist(win_ff.above_right, win_ff.below_mid)};
      c0 = pix_dist(win_ff.above_left, win_ff.below_right);
      c1 = pix_dist(win_ff.above_mid, win_ff.below_mid);
      c2 = pix_dist(win_ff.above_right, win_ff.below_left);
   end

   // Direction choice; ties go to the later direction, but c2 loses to c_first.
   always_comb begin
      dir_first = (c0 < c1) ? DirUpLeft : DirVert;
      c_first   = (c0 < c1) ? c0 : c1;
      if (p_sum > q_sum) begin
         dir_pick = dir_first;
      end else if (p_sum < q_sum) begin
         dir_pick = (c1 < c2) ? DirVert : DirUpRight;
      end else begin
         dir_pick = (c2 < c_first) ? DirUpRight : dir_first;
      end
   end

   // Average the pair along the chosen direction.
   always_comb begin
      unique case (dir_pick)
         DirUpLeft: avg_pick = pix_avg(win_ff.above_left, win_ff.below_right);
         DirVert:   avg_pick = pix_avg(win_ff.above_mid, win_ff.below_mid);
         default:   avg_pick = pix_avg(win_ff.above_right, win_ff.below_left);
      endcase
   end

   always_ff @(posedge clock) begin
      if (res_load && win_valid_ff) begin
         res_pixel_ff <= avg_pick;
         res_dir_ff   <= dir_pick;
      end
   end

   assign rsp_valid        = res_valid_ff;
   assign rsp_filled_pixel = res_pixel_ff;
   assign rsp_direction    = res_dir_ff;

   // An accepted transaction always lands in the input register.
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> win_valid_ff)
      else $error("accepted transaction not held in input register");

   // A window blocked behind a waiting result is kept, not dropped.
   a_win_held: assert property (@(posedge clock) disable iff (reset)
      (win_valid_ff && req_stall) |=> win_valid_ff)
      else $error("stalled window lost");

   // A new result only appears when the input register held a window.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (res_load && !res_valid_in) |-> !win_valid_ff)
      else $error("result register emptied while a window was waiting");

   // A result is never dropped while the consumer stalls.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && rsp_stall) |=> (res_valid_ff && $stable(res_dir_ff)))
      else $error("stalled result changed or dropped");

endmodule
